FILE: hw/rtl/lawt_pkg.sv
package lawt_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W = 16;

  localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROW   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;

  // out_tdata: out_byte, word_length, truncated, padded to whole bytes
  localparam int unsigned OUT_DATA_W = 32;

  typedef logic [LEN_W-1:0] len_t;

  // ascii digits and letters, c locale
  function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
    logic digit;
    logic upper;
    logic lower;
    digit = (c >= 8'h30) && (c <= 8'h39);
    upper = (c >= 8'h41) && (c <= 8'h5A);
    lower = (c >= 8'h61) && (c <= 8'h7A);
    return digit || upper || lower;
  endfunction

endpackage

FILE: hw/rtl/longest_alnum_word_tracker.sv
// text, end-of-row and clear beats: one per cycle, back to back while in_tready is high, no result
// read beat: one result per stored byte (or a single null result), each byte passed through
// the memory read port and output register; a new read waits for the last one and a free output
// in_tready is low from the read beat until its last memory read or its null result is issued
// reset clears best length, run length, bank select and handshake state;
// the word memory is not cleared and needs no clearing pass
module longest_alnum_word_tracker
  import lawt_pkg::*;
#(
  parameter int unsigned MAX_WORD = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte[7:0]
  input  logic [1:0]            in_tuser,   // mode[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_byte[7:0], word_length[23:8], truncated[24]
  output logic [0:0]            out_tuser,  // is_null[0]
  output logic                  out_tlast
);

  localparam int unsigned DEPTH = 2 * MAX_WORD;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned KW = $clog2(MAX_WORD + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state_r, state_nxt;
  logic              best_bank_r, best_bank_nxt;
  len_t              best_len_r, best_len_nxt;
  len_t              run_len_r, run_len_nxt;
  logic [KW-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              rd_last_r, rd_last_nxt;

  logic [BYTE_W-1:0] word_mem_r [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  len_t              out_len_r;
  logic              out_null_r;
  logic              out_trunc_r;
  logic              out_last_r;

  logic              in_acc;
  logic [MODE_W-1:0] in_mode;
  logic [BYTE_W-1:0] in_byte;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              issue_ok;
  logic              null_load;
  logic [KW-1:0]     rd_count;
  logic              rd_is_last;
  logic              best_trunc;
  logic [AW-1:0]     best_base;
  logic [AW-1:0]     run_base;
  logic              run_done;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign in_mode = in_tuser;
  assign in_byte = in_tdata;

  assign best_base = best_bank_r ? AW'(MAX_WORD) : '0;
  assign run_base = best_bank_r ? '0 : AW'(MAX_WORD);
  assign wr_addr = run_base + AW'(run_len_r);
  assign rd_addr = best_base + AW'(rd_cnt_r);

  assign rd_count = (best_len_r < len_t'(MAX_WORD)) ? KW'(best_len_r) : KW'(MAX_WORD);
  assign rd_is_last = ((rd_cnt_r + KW'(1)) == rd_count);
  assign best_trunc = (best_len_r > len_t'(MAX_WORD));
  assign run_done = (run_len_r > best_len_r);

  // only issue a read when the output register is free by the time data lands
  assign issue_ok = (state_r == ST_READ) && !rd_pend_r && (!out_valid_r || out_tready);
  assign null_load = issue_ok && (best_len_r == '0);

  always_comb begin
    state_nxt = state_r;
    best_bank_nxt = best_bank_r;
    best_len_nxt = best_len_r;
    run_len_nxt = run_len_r;
    rd_cnt_nxt = rd_cnt_r;
    rd_pend_nxt = 1'b0;
    rd_last_nxt = rd_last_r;
    wr_en = 1'b0;
    rd_en = 1'b0;

    if (in_acc) begin
      case (in_mode)
        MODE_TEXT: begin
          if (is_word_char(in_byte)) begin
            wr_en = (run_len_r < len_t'(MAX_WORD));
            if (run_len_r != LEN_MAX) begin
              run_len_nxt = run_len_r + len_t'(1);
            end
          end else if (run_len_r != '0) begin
            if (run_done) begin
              best_len_nxt = run_len_r;
              best_bank_nxt = ~best_bank_r;
            end
            run_len_nxt = '0;
          end
        end
        MODE_ROW: begin
          if (run_len_r != '0) begin
            if (run_done) begin
              best_len_nxt = run_len_r;
              best_bank_nxt = ~best_bank_r;
            end
            run_len_nxt = '0;
          end
        end
        MODE_CLEAR: begin
          best_len_nxt = '0;
          run_len_nxt = '0;
        end
        MODE_READ: begin
          state_nxt = ST_READ;
          rd_cnt_nxt = '0;
        end
        default: begin
          state_nxt = state_r;
        end
      endcase
    end

    if (issue_ok) begin
      if (null_load) begin
        state_nxt = ST_IDLE;
      end else begin
        rd_en = 1'b1;
        rd_pend_nxt = 1'b1;
        rd_last_nxt = rd_is_last;
        rd_cnt_nxt = rd_cnt_r + KW'(1);
        if (rd_is_last) begin
          state_nxt = ST_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      best_bank_r <= 1'b0;
      best_len_r <= '0;
      run_len_r <= '0;
      rd_cnt_r <= '0;
      rd_pend_r <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      best_bank_r <= best_bank_nxt;
      best_len_r <= best_len_nxt;
      run_len_r <= run_len_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      rd_pend_r <= rd_pend_nxt;
      rd_last_r <= rd_last_nxt;
    end
  end

  // word memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_mem_r[wr_addr] <= in_byte;
    end
    if (rd_en) begin
      rd_data_r <= word_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_pend_r || null_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_byte_r <= rd_data_r;
      out_len_r <= best_len_r;
      out_null_r <= 1'b0;
      out_trunc_r <= best_trunc;
      out_last_r <= rd_last_r;
    end else if (null_load) begin
      out_byte_r <= '0;
      out_len_r <= '0;
      out_null_r <= 1'b1;
      out_trunc_r <= 1'b0;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {7'd0, out_trunc_r, out_len_r, out_byte_r};
  assign out_tuser = out_null_r;
  assign out_tlast = out_last_r;

  // read data never lands on a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("memory read data would overwrite a pending result");

  // best word cannot move while it is being walked
  a_best_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> $stable(best_len_r) && $stable(best_bank_r))
    else $error("best word changed during readout");

  // a null result is a lone, all-zero last beat
  a_null_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_null_r) |-> out_last_r && (out_len_r == '0) && !out_trunc_r)
    else $error("malformed null result");

  // a read only starts from idle and the run in progress survives it
  a_run_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> $stable(run_len_r))
    else $error("word in progress changed during readout");

endmodule
